FILE: src/subpage_access_heatmap_table_core_assert.svh
// Assertion macros for the subpage access heatmap table.
`ifndef SUBPAGE_ACCESS_HEATMAP_TABLE_CORE_ASSERT_SVH
`define SUBPAGE_ACCESS_HEATMAP_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SAHM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sahm assertion failed");

// Next-cycle implication, disabled during reset.
`define SAHM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sahm assertion failed");

`endif

FILE: src/sahm_pkg.sv
// Shared constants, codes and types of the subpage access heatmap table.
`default_nettype none
package sahm_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int SUBPAGES      = 512;
  localparam int COUNT_WIDTH   = 32;

  localparam int SUB_W   = $clog2(SUBPAGES);
  localparam int TAG_W   = 31;
  localparam int TIME_W  = 32;
  localparam int TTL_W   = 31;
  localparam int ENT_W   = $clog2(TABLE_ENTRIES);
  localparam int VCNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int CADDR_W = ENT_W + SUB_W;
  localparam int SUM_W   = COUNT_WIDTH + SUB_W;
  localparam int TOT_W   = 48;
  localparam int WORDS   = SUBPAGES / 64;
  localparam int WI_W    = $clog2(WORDS);
  localparam int CC_W    = 10;
  localparam int EC_W    = 11;
  localparam int HP_W    = 7;
  localparam int MAX_ORDER = 9;

  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_PRUNE  = 2'd2;
  localparam logic [1:0] CMD_STATS  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DROP   = 2'd1;
  localparam logic [1:0] ST_NODATA = 2'd2;
  localparam logic [1:0] ST_BADORD = 2'd3;

  localparam logic       REG_TTL   = 1'b0;
  localparam logic [TTL_W-1:0] TTL_RESET = 31'd30000;

  typedef struct packed {
    logic [TAG_W-1:0]       tag;
    logic [TIME_W-1:0]      stamp;
    logic [COUNT_WIDTH-1:0] total;
  } meta_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [63:0]      bitmap_word;
    logic [WI_W-1:0]  word_index;
    logic             last_word;
    logic [HP_W-1:0]  hot_percent;
    logic [CC_W-1:0]  chunk_count;
    logic [EC_W-1:0]  entry_count;
    logic [TOT_W-1:0] access_total;
  } result_t;

endpackage
`default_nettype wire

FILE: src/sahm_ram.sv
// Generic one-write, one-read synchronous RAM with registered read data.
`default_nettype none
module sahm_ram #(
  parameter int W = 32,
  parameter int D = 64,
  parameter int AW = $clog2(D)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: src/sahm_outreg.sv
// Output register of the result channel.
`default_nettype none
module sahm_outreg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire sahm_pkg::result_t res,
  output logic                   ready,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sahm_pkg::result_t      out_res
);

  // take a new request when empty or when the held one leaves
  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= push;
    end
    if (ready && push) begin
      out_res <= res;
    end
  end

endmodule
`default_nettype wire

FILE: src/sahm_ctrl.sv
// Sequencer of the heatmap table: tag walk, prune, counter update and query passes.
`default_nettype none
module sahm_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   command,
  input  wire logic [39:0]                  page_number,
  input  wire logic [3:0]                   chunk_order,
  input  wire logic [31:0]                  now_ticks,
  input  wire logic [sahm_pkg::TTL_W-1:0]   entry_ttl,
  output logic                              res_valid,
  output sahm_pkg::result_t                 res,
  input  wire logic                         res_ready
);

  localparam int EW = sahm_pkg::ENT_W;
  localparam int SW = sahm_pkg::SUB_W;
  localparam int CW = sahm_pkg::COUNT_WIDTH;
  localparam int MW = sahm_pkg::SUM_W;
  localparam int NE = sahm_pkg::TABLE_ENTRIES;
  localparam int TW = sahm_pkg::TOT_W;

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_DECODE    = 5'd1;
  localparam logic [4:0] S_FIND_RD   = 5'd2;
  localparam logic [4:0] S_FIND_CHK  = 5'd3;
  localparam logic [4:0] S_PRUNE_RD  = 5'd4;
  localparam logic [4:0] S_PRUNE_CHK = 5'd5;
  localparam logic [4:0] S_PRUNE_END = 5'd6;
  localparam logic [4:0] S_ALLOC     = 5'd7;
  localparam logic [4:0] S_CLEAR     = 5'd8;
  localparam logic [4:0] S_UPD_RD    = 5'd9;
  localparam logic [4:0] S_UPD_WR    = 5'd10;
  localparam logic [4:0] S_STAT_RD   = 5'd11;
  localparam logic [4:0] S_STAT_CHK  = 5'd12;
  localparam logic [4:0] S_Q_PASS    = 5'd13;
  localparam logic [4:0] S_Q_SETUP   = 5'd14;
  localparam logic [4:0] S_Q_EMIT    = 5'd15;
  localparam logic [4:0] S_ONE       = 5'd16;

  logic [4:0]  state;
  logic [1:0]  cmd_r;
  logic [sahm_pkg::TAG_W-1:0] tag_r;
  logic [SW-1:0] sub_r;
  logic [3:0]  order_r;
  logic [31:0] now_r;
  logic [1:0]  one_status;

  logic [NE-1:0] valid_bits;
  logic [sahm_pkg::VCNT_W-1:0] valid_count;
  logic [EW-1:0] idx;
  logic [EW-1:0] hit_idx;
  logic [CW-1:0] hit_total;
  logic          free_found;
  logic [EW-1:0] free_idx;
  logic [TW-1:0] stat_total;

  logic [SW:0]   j;
  logic          rd_pend;
  logic [SW-1:0] rd_j;
  logic          pass2;
  logic [MW-1:0] acc;
  logic [MW-1:0] peak;
  logic [SW:0]   hot;
  logic [sahm_pkg::WORDS-1:0][63:0] words;
  logic [sahm_pkg::WI_W-1:0] w;

  // memory ports
  logic                   meta_we;
  logic [EW-1:0]          meta_waddr;
  sahm_pkg::meta_t        meta_wdata;
  sahm_pkg::meta_t        meta_rdata;
  logic [EW-1:0]          meta_raddr;
  logic                   cnt_we;
  logic [sahm_pkg::CADDR_W-1:0] cnt_waddr;
  logic [CW-1:0]          cnt_wdata;
  logic [sahm_pkg::CADDR_W-1:0] cnt_raddr;
  logic [CW-1:0]          cnt_rdata;

  // derived values
  logic          tag_hit;
  logic          stale;
  logic [31:0]   deadline;
  logic [31:0]   age;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] tot_inc;
  logic [TW:0]   stat_sum;
  logic [SW-1:0] cmask;
  logic [SW-1:0] chunk;
  logic          chunk_first;
  logic          chunk_last;
  logic [MW-1:0] csum;
  logic [MW+3:0] csum10;
  logic          hot_chunk;
  logic [16:0]   hot100;
  logic [3:0]    nwords;
  logic          w_last;

  sahm_ram #(.W($bits(sahm_pkg::meta_t)), .D(NE)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_rdata)
  );

  sahm_ram #(.W(CW), .D(NE * sahm_pkg::SUBPAGES)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  assign in_stall = (state != S_IDLE);

  // entry compare and stale test on the meta read data
  assign tag_hit  = valid_bits[idx] && (meta_rdata.tag == tag_r);
  assign deadline = now_r - {1'b0, entry_ttl};
  assign age      = meta_rdata.stamp - deadline;
  assign stale    = age[31];
  assign cnt_inc  = (&cnt_rdata) ? cnt_rdata : cnt_rdata + 1'b1;
  assign tot_inc  = (&hit_total) ? hit_total : hit_total + 1'b1;
  assign stat_sum = {1'b0, stat_total} + (TW + 1)'(meta_rdata.total);

  // chunk bookkeeping for the query passes
  assign cmask       = ~({SW{1'b1}} << order_r);
  assign chunk       = rd_j >> order_r;
  assign chunk_first = (rd_j & cmask) == '0;
  assign chunk_last  = (rd_j & cmask) == cmask;
  assign csum        = (chunk_first ? '0 : acc) + MW'(cnt_rdata);

  // hot when sum >= max(peak / 10, 1), i.e. sum nonzero and 10 * sum + 9 >= peak
  assign csum10    = {1'b0, csum, 3'b000} + {3'b000, csum, 1'b0} + (MW + 4)'(9);
  assign hot_chunk = (csum != '0) && (csum10 >= (MW + 4)'(peak));

  assign hot100 = 17'(hot) * 17'd100;
  assign nwords = (order_r >= 4'd3) ? 4'd1 : (4'd8 >> order_r);
  assign w_last = ({1'b0, w} == nwords - 4'd1);

  // memory address and write selection
  always_comb begin
    meta_raddr = idx;
    meta_we    = 1'b0;
    meta_waddr = hit_idx;
    meta_wdata = '{tag: tag_r, stamp: now_r, total: tot_inc};
    cnt_we     = 1'b0;
    cnt_waddr  = {hit_idx, sub_r};
    cnt_wdata  = cnt_inc;
    cnt_raddr  = {hit_idx, j[SW-1:0]};
    unique case (state)
      S_ALLOC: begin
        meta_we    = 1'b1;
        meta_waddr = free_idx;
        meta_wdata = '{tag: tag_r, stamp: now_r, total: CW'(1)};
      end
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = {hit_idx, j[SW-1:0]};
        cnt_wdata = (j[SW-1:0] == sub_r) ? CW'(1) : '0;
      end
      S_UPD_RD: begin
        cnt_raddr = {hit_idx, sub_r};
      end
      S_UPD_WR: begin
        cnt_we  = 1'b1;
        meta_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result assembly
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    if (state == S_ONE) begin
      res_valid     = 1'b1;
      res.status    = one_status;
      res.last_word = 1'b1;
      if (cmd_r == sahm_pkg::CMD_PRUNE || cmd_r == sahm_pkg::CMD_STATS) begin
        res.entry_count = sahm_pkg::EC_W'(valid_count);
      end
      if (cmd_r == sahm_pkg::CMD_STATS) begin
        res.access_total = stat_total;
      end
    end else if (state == S_Q_EMIT) begin
      res_valid       = 1'b1;
      res.status      = sahm_pkg::ST_OK;
      res.bitmap_word = words[w];
      res.word_index  = w;
      res.last_word   = w_last;
      res.hot_percent = sahm_pkg::HP_W'(hot100 >> (4'd9 - order_r));
      res.chunk_count = sahm_pkg::CC_W'(10'd512 >> order_r);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      valid_bits  <= '0;
      valid_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= command;
            tag_r   <= page_number[39:SW];
            sub_r   <= page_number[SW-1:0];
            order_r <= chunk_order;
            now_r   <= now_ticks;
            state   <= S_DECODE;
          end
        end
        S_DECODE: begin
          idx        <= '0;
          free_found <= 1'b0;
          stat_total <= '0;
          unique case (cmd_r)
            sahm_pkg::CMD_RECORD: state <= S_FIND_RD;
            sahm_pkg::CMD_QUERY: begin
              if (order_r >= 4'(sahm_pkg::MAX_ORDER)) begin
                one_status <= sahm_pkg::ST_BADORD;
                state      <= S_ONE;
              end else if (sub_r != '0) begin
                one_status <= sahm_pkg::ST_NODATA;
                state      <= S_ONE;
              end else begin
                state <= S_FIND_RD;
              end
            end
            sahm_pkg::CMD_PRUNE: state <= S_PRUNE_RD;
            sahm_pkg::CMD_STATS: state <= S_STAT_RD;
          endcase
        end
        S_FIND_RD: state <= S_FIND_CHK;
        S_FIND_CHK: begin
          if (!valid_bits[idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
          if (tag_hit) begin
            hit_idx   <= idx;
            hit_total <= meta_rdata.total;
            if (cmd_r == sahm_pkg::CMD_RECORD) begin
              state <= S_UPD_RD;
            end else if (meta_rdata.total == '0) begin
              one_status <= sahm_pkg::ST_NODATA;
              state      <= S_ONE;
            end else begin
              j       <= '0;
              rd_pend <= 1'b0;
              pass2   <= 1'b0;
              peak    <= '0;
              state   <= S_Q_PASS;
            end
          end else if (idx == EW'(NE - 1)) begin
            if (cmd_r != sahm_pkg::CMD_RECORD) begin
              one_status <= sahm_pkg::ST_NODATA;
              state      <= S_ONE;
            end else if (valid_count == sahm_pkg::VCNT_W'(NE)) begin
              idx        <= '0;
              free_found <= 1'b0;
              state      <= S_PRUNE_RD;
            end else begin
              state <= S_ALLOC;
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= S_FIND_RD;
          end
        end
        S_PRUNE_RD: state <= S_PRUNE_CHK;
        S_PRUNE_CHK: begin
          if (valid_bits[idx] && stale) begin
            valid_bits[idx] <= 1'b0;
            valid_count     <= valid_count - 1'b1;
          end
          if ((!valid_bits[idx] || stale) && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
          if (idx == EW'(NE - 1)) begin
            state <= S_PRUNE_END;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_PRUNE_RD;
          end
        end
        S_PRUNE_END: begin
          if (cmd_r != sahm_pkg::CMD_RECORD) begin
            one_status <= sahm_pkg::ST_OK;
            state      <= S_ONE;
          end else if (valid_count < sahm_pkg::VCNT_W'(NE)) begin
            state <= S_ALLOC;
          end else begin
            one_status <= sahm_pkg::ST_DROP;
            state      <= S_ONE;
          end
        end
        S_ALLOC: begin
          valid_bits[free_idx] <= 1'b1;
          valid_count          <= valid_count + 1'b1;
          hit_idx              <= free_idx;
          j                    <= '0;
          state                <= S_CLEAR;
        end
        S_CLEAR: begin
          j <= j + 1'b1;
          if (j[SW-1:0] == {SW{1'b1}}) begin
            one_status <= sahm_pkg::ST_OK;
            state      <= S_ONE;
          end
        end
        S_UPD_RD: state <= S_UPD_WR;
        S_UPD_WR: begin
          one_status <= sahm_pkg::ST_OK;
          state      <= S_ONE;
        end
        S_STAT_RD: state <= S_STAT_CHK;
        S_STAT_CHK: begin
          if (valid_bits[idx]) begin
            stat_total <= stat_sum[TW] ? {TW{1'b1}} : stat_sum[TW-1:0];
          end
          if (idx == EW'(NE - 1)) begin
            one_status <= sahm_pkg::ST_OK;
            state      <= S_ONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_STAT_RD;
          end
        end
        S_Q_PASS: begin
          // stream the subpage counters, one read issued per cycle
          if (!j[SW]) begin
            j <= j + 1'b1;
          end
          rd_pend <= !j[SW];
          rd_j    <= j[SW-1:0];
          if (rd_pend) begin
            acc <= csum;
            if (chunk_last) begin
              if (!pass2) begin
                if (csum > peak) begin
                  peak <= csum;
                end
              end else if (hot_chunk) begin
                words[chunk[SW-1:6]][chunk[5:0]] <= 1'b1;
                hot <= hot + 1'b1;
              end
            end
            if (rd_j == {SW{1'b1}}) begin
              if (!pass2) begin
                state <= S_Q_SETUP;
              end else begin
                w     <= '0;
                state <= S_Q_EMIT;
              end
            end
          end
        end
        S_Q_SETUP: begin
          // restart the counter stream for the hot-bit pass
          j       <= '0;
          rd_pend <= 1'b0;
          pass2   <= 1'b1;
          hot     <= '0;
          words   <= '0;
          state   <= S_Q_PASS;
        end
        S_Q_EMIT: begin
          if (res_ready) begin
            w <= w + 1'b1;
            if (w_last) begin
              state <= S_IDLE;
            end
          end
        end
        S_ONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/subpage_access_heatmap_table_core.sv
// Top level of the subpage access heatmap table: config port, sequencer, output register.
//
// Requests enter on in_valid/in_stall with command, page_number, chunk_order and
// now_ticks; one request is worked at a time, and in_stall is high while it is.
// Results leave on out_valid/out_stall through an output register, so the next
// request is taken while the last result still waits.
// Record hit: a walk of the entry memory up to the match, then a counter update.
// Record miss: a walk of the entry memory, another walk for a prune when the
// table is full, then a clear of the new row.
// Query: tag walk, two passes over the counter memory (peak, then hot bits)
// with a setup state between them, then one result per 64-chunk word.
// Prune and statistics: a walk of the entry memory, one result.
// The counter memory port takes one read per cycle.
// Reset empties the table and sets entry_ttl to 30000; the memories need no sweep.
// While the receiver stalls, results hold and the sequencer waits.
// entry_ttl is written over the APB port at address 0.
`default_nettype none
module subpage_access_heatmap_table_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [39:0] page_number,
  input  wire logic [3:0]  chunk_order,
  input  wire logic [31:0] now_ticks,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [63:0]      bitmap_word,
  output logic [2:0]       word_index,
  output logic             last_word,
  output logic [6:0]       hot_percent,
  output logic [9:0]       chunk_count,
  output logic [10:0]      entry_count,
  output logic [47:0]      access_total,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [sahm_pkg::TTL_W-1:0] entry_ttl;
  logic                       res_valid;
  logic                       res_ready;
  sahm_pkg::result_t          res;
  sahm_pkg::result_t          out_res;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == sahm_pkg::REG_TTL) ? {1'b0, entry_ttl} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_ttl <= sahm_pkg::TTL_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == sahm_pkg::REG_TTL) begin
      entry_ttl <= pwdata[sahm_pkg::TTL_W-1:0];
    end
  end

  sahm_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .page_number(page_number),
    .chunk_order(chunk_order), .now_ticks(now_ticks),
    .entry_ttl(entry_ttl),
    .res_valid(res_valid), .res(res), .res_ready(res_ready)
  );

  sahm_outreg u_out (
    .clk(clk), .rst(rst),
    .push(res_valid), .res(res), .ready(res_ready),
    .out_valid(out_valid), .out_stall(out_stall), .out_res(out_res)
  );

  assign status       = out_res.status;
  assign bitmap_word  = out_res.bitmap_word;
  assign word_index   = out_res.word_index;
  assign last_word    = out_res.last_word;
  assign hot_percent  = out_res.hot_percent;
  assign chunk_count  = out_res.chunk_count;
  assign entry_count  = out_res.entry_count;
  assign access_total = out_res.access_total;

endmodule
`default_nettype wire

FILE: src/sahm_checker.sv
// Port-level checks of the heatmap table, bound to the top level.
`default_nettype none
`include "subpage_access_heatmap_table_core_assert.svh"
module sahm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  command,
  input wire logic [39:0] page_number,
  input wire logic [3:0]  chunk_order,
  input wire logic [31:0] now_ticks,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  status,
  input wire logic [63:0] bitmap_word,
  input wire logic [2:0]  word_index,
  input wire logic        last_word,
  input wire logic [6:0]  hot_percent,
  input wire logic [9:0]  chunk_count,
  input wire logic [10:0] entry_count,
  input wire logic [47:0] access_total,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  // a stalled result holds
  `SAHM_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(bitmap_word) && $stable(status))
  // error results are single and carry no bitmap
  `SAHM_ASSERT_IMP(a_err_single, clk, rst, out_valid && status != sahm_pkg::ST_OK, last_word && word_index == 3'd0 && bitmap_word == 64'd0)
  // entry count never exceeds the table
  `SAHM_ASSERT_IMP(a_count_max, clk, rst, out_valid, entry_count <= 11'(sahm_pkg::TABLE_ENTRIES))
  // percentage stays in range
  `SAHM_ASSERT_IMP(a_pct_max, clk, rst, out_valid, hot_percent <= 7'd100)

endmodule

bind subpage_access_heatmap_table_core sahm_checker u_sahm_checker (.*);
`default_nettype wire

FILE: test/tb_subpage_access_heatmap_table_core.sv
// Testbench for the subpage access heatmap table: random and directed requests checked by a scoreboard.
`default_nettype none
module tb_subpage_access_heatmap_table_core;
  import sahm_pkg::*;

  // Predicts the results of each accepted request and checks arriving results in order
  class heatmap_scoreboard;
    logic [30:0] ttl;
    bit          slot_valid [TABLE_ENTRIES];
    logic [30:0] slot_tag [TABLE_ENTRIES];
    logic [31:0] slot_stamp [TABLE_ENTRIES];
    logic [31:0] slot_total [TABLE_ENTRIES];
    logic [31:0] hits [TABLE_ENTRIES][SUBPAGES];
    int          live_slots;
    result_t     pending [$];
    int          errors;

    function void clear();
      ttl = TTL_RESET;
      foreach (slot_valid[i]) slot_valid[i] = 0;
      live_slots = 0;
      pending.delete();
      errors = 0;
    endfunction

    function int find_slot(logic [30:0] tag);
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (slot_valid[i] && slot_tag[i] == tag) return i;
      return -1;
    endfunction

    // Drop entries whose last access lies past the deadline, wrap-aware
    function void drop_stale(logic [31:0] now);
      logic [31:0] deadline;
      logic [31:0] diff;
      deadline = now - {1'b0, ttl};
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        diff = slot_stamp[i] - deadline;
        if (slot_valid[i] && diff[31]) begin
          slot_valid[i] = 0;
          live_slots--;
        end
      end
    endfunction

    function result_t blank(logic [1:0] st);
      result_t r;
      r = '0;
      r.status = st;
      r.last_word = 1'b1;
      return r;
    endfunction

    function void note_request(logic [1:0] cmd, logic [39:0] pn, logic [3:0] ord,
                               logic [31:0] now);
      int          e;
      int          nchunks;
      int          span;
      int          hot;
      int          nwords;
      logic [63:0] sums [SUBPAGES];
      logic [63:0] peak;
      logic [63:0] thresh;
      logic [63:0] words [WORDS];
      logic [47:0] tot;
      result_t     r;
      case (cmd)
        CMD_RECORD: begin
          e = find_slot(pn[39:9]);
          if (e < 0) begin
            if (live_slots >= TABLE_ENTRIES) drop_stale(now);
            for (int i = 0; i < TABLE_ENTRIES && e < 0; i++)
              if (!slot_valid[i]) e = i;
            if (e < 0) begin
              pending.push_back(blank(ST_DROP));
              return;
            end
            slot_valid[e] = 1;
            slot_tag[e] = pn[39:9];
            slot_total[e] = 0;
            for (int j = 0; j < SUBPAGES; j++) hits[e][j] = 0;
            live_slots++;
          end
          if (hits[e][pn[8:0]] != '1) hits[e][pn[8:0]]++;
          if (slot_total[e] != '1) slot_total[e]++;
          slot_stamp[e] = now;
          pending.push_back(blank(ST_OK));
        end
        CMD_QUERY: begin
          if (ord >= MAX_ORDER) begin
            pending.push_back(blank(ST_BADORD));
            return;
          end
          e = (pn[8:0] == 0) ? find_slot(pn[39:9]) : -1;
          if (e < 0 || slot_total[e] == 0) begin
            pending.push_back(blank(ST_NODATA));
            return;
          end
          nchunks = SUBPAGES >> ord;
          span = 1 << ord;
          peak = 0;
          for (int i = 0; i < nchunks; i++) begin
            sums[i] = 0;
            for (int j = 0; j < span; j++) sums[i] += hits[e][i * span + j];
            if (sums[i] > peak) peak = sums[i];
          end
          thresh = peak / 10;
          if (thresh < 1) thresh = 1;
          foreach (words[w]) words[w] = 0;
          hot = 0;
          for (int i = 0; i < nchunks; i++)
            if (sums[i] >= thresh) begin
              words[i / 64][i % 64] = 1'b1;
              hot++;
            end
          nwords = (nchunks + 63) / 64;
          for (int w = 0; w < nwords; w++) begin
            r = '0;
            r.status = ST_OK;
            r.bitmap_word = words[w];
            r.word_index = WI_W'(w);
            r.last_word = (w == nwords - 1);
            r.hot_percent = HP_W'(hot * 100 / nchunks);
            r.chunk_count = CC_W'(nchunks);
            pending.push_back(r);
          end
        end
        CMD_PRUNE: begin
          drop_stale(now);
          r = blank(ST_OK);
          r.entry_count = EC_W'(live_slots);
          pending.push_back(r);
        end
        default: begin
          tot = 0;
          for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot_valid[i]) tot += 48'(slot_total[i]);
          r = blank(ST_OK);
          r.entry_count = EC_W'(live_slots);
          r.access_total = tot;
          pending.push_back(r);
        end
      endcase
    endfunction

    function void check(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status != want.status) report("status", want.status, got.status);
      if (got.bitmap_word != want.bitmap_word)
        report("bitmap_word", want.bitmap_word, got.bitmap_word);
      if (got.word_index != want.word_index)
        report("word_index", want.word_index, got.word_index);
      if (got.last_word != want.last_word)
        report("last_word", want.last_word, got.last_word);
      if (got.hot_percent != want.hot_percent)
        report("hot_percent", want.hot_percent, got.hot_percent);
      if (got.chunk_count != want.chunk_count)
        report("chunk_count", want.chunk_count, got.chunk_count);
      if (got.entry_count != want.entry_count)
        report("entry_count", want.entry_count, got.entry_count);
      if (got.access_total != want.access_total)
        report("access_total", want.access_total, got.access_total);
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
      $display("%0t: %s expected %h actual %h", $realtime, field, want, got);
      errors++;
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  command;
  logic [39:0] page_number;
  logic [3:0]  chunk_order;
  logic [31:0] now_ticks;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [63:0] bitmap_word;
  logic [2:0]  word_index;
  logic        last_word;
  logic [6:0]  hot_percent;
  logic [9:0]  chunk_count;
  logic [10:0] entry_count;
  logic [47:0] access_total;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  heatmap_scoreboard sb;
  logic [31:0] clock_now;
  logic [30:0] tag_pool [96];
  int          burst_left;
  int          fresh_tag;
  bit          long_hold;

  subpage_access_heatmap_table_core u_top (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < 4000000) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Stall the result side: quiet stretches, random stalls, one long hold-off
  initial begin
    out_stall = 1'b1;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        long_hold = 0;
      end
      if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        repeat ($urandom_range(20, 80)) begin
          out_stall <= ($urandom_range(0, 99) < 40);
          @(posedge clk);
        end
      end
    end
  end

  // Check every result taken
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check('{status, bitmap_word, word_index, last_word, hot_percent, chunk_count,
                 entry_count, access_total});
  end

  // Offer one request and hold it until taken; open gaps between bursts
  task automatic send(logic [1:0] cmd, logic [39:0] pn, logic [3:0] ord, logic [31:0] now);
    in_valid <= 1'b1;
    command <= cmd;
    page_number <= pn;
    chunk_order <= ord;
    now_ticks <= now;
    do @(posedge clk); while (in_stall);
    sb.note_request(cmd, pn, ord, now);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  endtask

  // Hold the sender until every expected result has arrived
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_ttl(logic [30:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(4 * REG_TTL);
    pwdata <= {1'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.ttl = value;
  endtask

  // Advance the tick counter, sometimes by a wide jump
  function automatic logic [31:0] tick();
    if ($urandom_range(0, 30) == 0) clock_now += $urandom;
    else clock_now += $urandom_range(0, 3000);
    return clock_now;
  endfunction

  task automatic random_phase(int count);
    logic [30:0] tag;
    logic [8:0]  sub;
    int          pick;
    repeat (count) begin
      tag = ($urandom_range(0, 1)) ? tag_pool[$urandom_range(0, 7)]
                                   : tag_pool[$urandom_range(0, 95)];
      sub = ($urandom_range(0, 1)) ? 9'($urandom_range(0, 7) * 64) : 9'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send(CMD_RECORD, {tag, sub}, 4'($urandom), tick());
      end else if (pick < 78) begin
        // Mostly aligned bases with legal orders, some noise
        if ($urandom_range(0, 9) == 0)
          send(CMD_QUERY, {tag, 9'($urandom_range(1, 511))}, 4'($urandom), tick());
        else
          send(CMD_QUERY, {tag, 9'd0},
               ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8)),
               tick());
      end else if (pick < 88) begin
        send(CMD_PRUNE, 40'({$urandom, $urandom}), 4'($urandom), tick());
      end else begin
        send(CMD_STATS, 40'({$urandom, $urandom}), 4'($urandom), tick());
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_RECORD;
    page_number = '0;
    chunk_order = '0;
    now_ticks = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    long_hold = 0;
    burst_left = 0;
    clock_now = 0;
    fresh_tag = 1000;
    foreach (tag_pool[i]) tag_pool[i] = 31'($urandom);
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, every command, each query outcome
    send(CMD_RECORD, 40'd0, 4'd0, 32'd0);
    send(CMD_RECORD, '1, 4'hf, 32'hffff_ffff);
    send(CMD_RECORD, 40'd511, 4'd0, 32'd5);
    send(CMD_RECORD, 40'd511, 4'd0, 32'd6);
    send(CMD_RECORD, 40'd64, 4'd0, 32'd7);
    send(CMD_QUERY, 40'd0, 4'd0, 32'd8);
    send(CMD_QUERY, 40'd0, 4'd6, 32'd8);
    send(CMD_QUERY, 40'd0, 4'd7, 32'd8);
    send(CMD_QUERY, 40'd0, 4'd8, 32'd8);
    send(CMD_QUERY, 40'd0, 4'd9, 32'd8);
    send(CMD_QUERY, 40'd0, 4'hf, 32'd8);
    send(CMD_QUERY, 40'd5, 4'd3, 32'd8);
    send(CMD_QUERY, {31'h1234567, 9'd0}, 4'd2, 32'd8);
    send(CMD_QUERY, {31'h7fffffff, 9'd0}, 4'd1, 32'd8);
    send(CMD_STATS, '1, 4'hf, 32'd9);
    send(CMD_PRUNE, 40'd0, 4'd0, 32'd20000);
    send(CMD_PRUNE, 40'd0, 4'd0, 32'd100000);
    send(CMD_STATS, 40'd0, 4'd0, 32'd100000);
    drain();

    clock_now = 32'hffff_f000;
    random_phase(40);
    drain();

    // Fill the table with fresh tags and nothing stale, so the last misses drop
    write_ttl(31'h7fff_ffff);
    for (int i = 0; i < 66; i++) begin
      send(CMD_RECORD, {31'(fresh_tag), 9'($urandom)}, 4'd0, clock_now);
      fresh_tag++;
    end
    send(CMD_STATS, 40'd0, 4'd0, clock_now);
    drain();

    // Short TTL: misses on a full table prune first; receiver holds off once
    write_ttl(31'd1);
    long_hold = 1;
    random_phase(30);
    drain();

    write_ttl(31'($urandom_range(1000, 200000)));
    random_phase(20);
    drain();

    // Wait out the block's own walk before ending
    repeat (1500) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
